>>> src/catan_pkg.sv
package catan_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 16;
    localparam int unsigned STEP_COUNT_DEF  = 11;
    localparam int unsigned STEP_COUNT_MAX  = 11;

    localparam int unsigned ANGLE_WIDTH = 15;
    localparam int unsigned ACC_WIDTH   = 16;
    localparam int unsigned GUARD_BITS  = 3;

    localparam logic [ANGLE_WIDTH-1:0] HALF_CIRCLE    = 15'h4000;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_CIRCLE = 15'h2000;
    localparam logic [ANGLE_WIDTH-1:0] EIGHTH_CIRCLE  = 15'h1000;

    // arctangent of 2^-i, scaled so that a half circle is 4 * 16384
    localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [0:STEP_COUNT_MAX] = '{
        16'h4000, 16'h25c8, 16'h13f6, 16'h0a22, 16'h0516, 16'h028c,
        16'h0146, 16'h00a3, 16'h0051, 16'h0029, 16'h0014, 16'h000a
    };

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic [ANGLE_WIDTH-1:0] base;
    } t_ctl;

endpackage

>>> src/cordic_atan2_binary_radians_top.sv
// Four-quadrant arctangent of (y, x) in binary radians: a half circle is 16384 and the
// 15-bit result wraps at a full circle; y of zero gives 0, or 16384 for negative x.
// A word is taken on every cycle in which start is high (busy stays low), and its angle
// appears on o_angle, with o_valid high for one cycle, after it passes through one
// octant-fold stage, one stage per micro-rotation cell, and the output register. The
// pipeline always moves, so the receiver must take each word in the cycle it is shown.
module cordic_atan2_binary_radians_top import catan_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned STEP_COUNT  = STEP_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    output logic                          o_valid,
    output logic [ANGLE_WIDTH-1:0]        o_angle
);

    localparam int unsigned W = COORD_WIDTH + GUARD_BITS;

    t_ctl                        ctl_chain [0:STEP_COUNT];
    logic signed [W-1:0]         x_chain   [0:STEP_COUNT];
    logic signed [W-1:0]         y_chain   [0:STEP_COUNT];
    logic signed [ACC_WIDTH-1:0] acc_chain [0:STEP_COUNT];

    t_ctl                        last_ctl;
    logic signed [ACC_WIDTH-1:0] last_acc;
    logic [ANGLE_WIDTH-1:0]      n_angle;
    logic                        r_valid;
    logic [ANGLE_WIDTH-1:0]      r_angle;

    assign busy = 1'b0;

    catan_fold #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_coord_y(i_coord_y),
        .i_coord_x(i_coord_x),
        .o_ctl    (ctl_chain[0]),
        .o_x      (x_chain[0]),
        .o_y      (y_chain[0])
    );

    assign acc_chain[0] = '0;

    for (genvar g = 0; g < STEP_COUNT; g++) begin : g_cell
        catan_cell #(
            .COORD_WIDTH(COORD_WIDTH),
            .SHIFT      (g + 1)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl_chain[g]),
            .i_x    (x_chain[g]),
            .i_y    (y_chain[g]),
            .i_acc  (acc_chain[g]),
            .o_ctl  (ctl_chain[g+1]),
            .o_x    (x_chain[g+1]),
            .o_y    (y_chain[g+1]),
            .o_acc  (acc_chain[g+1])
        );
    end

    assign last_ctl = ctl_chain[STEP_COUNT];
    assign last_acc = acc_chain[STEP_COUNT];

    always_comb begin
        if (last_ctl.zero) begin
            n_angle = last_ctl.base;
        end else begin
            n_angle = last_ctl.base + {last_acc[ACC_WIDTH-1], last_acc[ACC_WIDTH-1:2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

>>> src/catan_fold.sv
module catan_fold import catan_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic signed [COORD_WIDTH-1:0]              i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]              i_coord_x,
    output t_ctl                                       o_ctl,
    output logic signed [COORD_WIDTH+GUARD_BITS-1:0]   o_x,
    output logic signed [COORD_WIDTH+GUARD_BITS-1:0]   o_y
);

    localparam int unsigned W = COORD_WIDTH + GUARD_BITS;

    logic signed [W-1:0]    x0, y0, x1, y1, x2, y2, n_x, n_y;
    logic [ANGLE_WIDTH-1:0] b1, b2, b3;
    t_ctl                   n_ctl;
    t_ctl                   r_ctl;
    logic signed [W-1:0]    r_x, r_y;

    always_comb begin
        x0 = {{GUARD_BITS{i_coord_x[COORD_WIDTH-1]}}, i_coord_x};
        y0 = {{GUARD_BITS{i_coord_y[COORD_WIDTH-1]}}, i_coord_y};

        // half circle: bring the point to the upper half plane
        if (y0[W-1]) begin
            x1 = -x0;
            y1 = -y0;
            b1 = HALF_CIRCLE;
        end else begin
            x1 = x0;
            y1 = y0;
            b1 = '0;
        end

        // quarter circle
        if (x1 <= 0) begin
            x2 = y1;
            y2 = -x1;
            b2 = b1 + QUARTER_CIRCLE;
        end else begin
            x2 = x1;
            y2 = y1;
            b2 = b1;
        end

        // eighth circle
        if (x2 <= y2) begin
            n_x = x2 + y2;
            n_y = y2 - x2;
            b3  = b2 + EIGHTH_CIRCLE;
        end else begin
            n_x = x2;
            n_y = y2;
            b3  = b2;
        end

        n_ctl.valid = i_valid;
        n_ctl.zero  = (y0 == '0);
        if (y0 == '0) begin
            n_ctl.base = x0[W-1] ? HALF_CIRCLE : '0;
        end else begin
            n_ctl.base = b3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

>>> src/catan_cell.sv
module catan_cell import catan_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned SHIFT       = 1
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  t_ctl                                       i_ctl,
    input  logic signed [COORD_WIDTH+GUARD_BITS-1:0]   i_x,
    input  logic signed [COORD_WIDTH+GUARD_BITS-1:0]   i_y,
    input  logic signed [ACC_WIDTH-1:0]                i_acc,
    output t_ctl                                       o_ctl,
    output logic signed [COORD_WIDTH+GUARD_BITS-1:0]   o_x,
    output logic signed [COORD_WIDTH+GUARD_BITS-1:0]   o_y,
    output logic signed [ACC_WIDTH-1:0]                o_acc
);

    localparam int unsigned W = COORD_WIDTH + GUARD_BITS;
    localparam logic signed [ACC_WIDTH-1:0] STEP_ANGLE = ATAN_TABLE[SHIFT];

    logic signed [W-1:0]         xs, ys, n_x, n_y;
    logic signed [ACC_WIDTH-1:0] n_acc;
    t_ctl                        r_ctl;
    logic signed [W-1:0]         r_x, r_y;
    logic signed [ACC_WIDTH-1:0] r_acc;

    always_comb begin
        xs = i_x >>> SHIFT;
        ys = i_y >>> SHIFT;
        if (!i_y[W-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + STEP_ANGLE;
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule
